// ----- design/ibfr_pkg.sv -----
// Shared constants and types for the iBUS frame receiver.
`timescale 1ns / 1ps

package ibfr_pkg;

    localparam int FRAME_LEN   = 32;
    localparam int ADDR_W      = $clog2(FRAME_LEN);
    localparam int BYTE_W      = 8;
    localparam int SUM_W       = 16;
    localparam int CHANNELS    = 14;
    localparam int CH_W        = 4;
    localparam int VALUE_W     = 12;
    localparam int HI_BITS     = VALUE_W - BYTE_W;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h20;
    localparam logic [BYTE_W-1:0] SECOND_BYTE = 8'h40;
    localparam logic [SUM_W-1:0]  SUM_INIT    = 16'hFFFF;

    // frame byte positions
    localparam logic [ADDR_W-1:0] POS_START   = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] POS_SECOND  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] POS_CH0     = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] POS_CHK_LO  = ADDR_W'(30);
    localparam logic [ADDR_W-1:0] POS_CHK_HI  = ADDR_W'(FRAME_LEN - 1);

    localparam logic [CH_W-1:0]   LAST_CH     = CH_W'(CHANNELS - 1);

    // command to the checksum accumulator
    typedef struct packed {
        logic              clr;
        logic              sub;
        logic [BYTE_W-1:0] data;
    } t_sum_cmd;

endpackage

// ----- design/ibfr_if.sv -----
// Valid/ready channel interfaces for received bytes and decoded channels.
`timescale 1ns / 1ps

interface ibfr_in_if;
    logic                      valid;
    logic                      ready;
    logic [ibfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ibfr_out_if;
    logic                         valid;
    logic                         ready;
    logic [ibfr_pkg::CH_W-1:0]    channel_index;
    logic [ibfr_pkg::VALUE_W-1:0] channel_value;
    logic                         last;

    modport source (output valid, output channel_index, output channel_value,
                    output last, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last, output ready);
endinterface

// ----- design/ibfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ibfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ibfr_sum.sv -----
// Checksum accumulator: one shared subtractor over the summed frame bytes.
`timescale 1ns / 1ps

module ibfr_sum (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ibfr_pkg::t_sum_cmd         i_cmd,
    output logic [ibfr_pkg::SUM_W-1:0] o_sum
);

    logic [ibfr_pkg::SUM_W-1:0] r_sum;
    logic [ibfr_pkg::SUM_W-1:0] n_sum;

    always_comb begin
        n_sum = r_sum;
        priority if (i_cmd.clr) begin
            n_sum = ibfr_pkg::SUM_INIT;
        end else if (i_cmd.sub) begin
            n_sum = r_sum - {{(ibfr_pkg::SUM_W - ibfr_pkg::BYTE_W){1'b0}}, i_cmd.data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= ibfr_pkg::SUM_INIT;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- design/ibfr_seq.sv -----
// Frame sequencer: byte framing, checksum check and channel readout.
`timescale 1ns / 1ps

module ibfr_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ibfr_in_if.sink                     i_in,
    ibfr_out_if.source                  o_out,
    output ibfr_pkg::t_sum_cmd          o_sum_cmd,
    input  logic [ibfr_pkg::SUM_W-1:0]  i_sum,
    output logic                        o_we,
    output logic [ibfr_pkg::ADDR_W-1:0] o_waddr,
    output logic [ibfr_pkg::BYTE_W-1:0] o_wdata,
    output logic [ibfr_pkg::ADDR_W-1:0] o_raddr,
    input  logic [ibfr_pkg::BYTE_W-1:0] i_rdata
);

    localparam logic [1:0] ST_RECV  = 2'd0;
    localparam logic [1:0] ST_RD_LO = 2'd1;
    localparam logic [1:0] ST_RD_HI = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [ibfr_pkg::ADDR_W-1:0]  r_pos, n_pos;
    logic [ibfr_pkg::CH_W-1:0]    r_ch, n_ch;
    logic [ibfr_pkg::BYTE_W-1:0]  r_chk_lo;
    logic [ibfr_pkg::BYTE_W-1:0]  r_lo;
    logic                         r_ovalid;
    logic [ibfr_pkg::CH_W-1:0]    r_oidx;
    logic [ibfr_pkg::VALUE_W-1:0] r_oval;
    logic                         r_olast;

    logic                         accept;
    logic                         load;
    logic [ibfr_pkg::ADDR_W-1:0]  lo_addr;
    logic [ibfr_pkg::ADDR_W-1:0]  hi_addr;
    logic [ibfr_pkg::BYTE_W-1:0]  rx;

    assign i_in.ready = (r_state == ST_RECV);
    assign accept     = i_in.valid && i_in.ready;
    assign rx         = i_in.rx_byte;

    // channel c sits at bytes 2c+2 (low) and 2c+3 (high)
    assign lo_addr = {r_ch, 1'b0} + ibfr_pkg::POS_CH0;
    assign hi_addr = {r_ch, 1'b1} + ibfr_pkg::POS_CH0;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_ch      = r_ch;
        o_sum_cmd = '0;
        o_sum_cmd.data = rx;
        o_we      = 1'b0;
        o_waddr   = r_pos;
        o_wdata   = rx;
        o_raddr   = lo_addr;
        load      = 1'b0;

        unique case (r_state)
            ST_RECV: begin
                if (accept) begin
                    priority if (r_pos == ibfr_pkg::POS_START) begin
                        if (rx == ibfr_pkg::START_BYTE) begin
                            o_we          = 1'b1;
                            o_sum_cmd.sub = 1'b1;
                            n_pos         = ibfr_pkg::POS_SECOND;
                        end
                    end else if (r_pos == ibfr_pkg::POS_SECOND &&
                                 rx != ibfr_pkg::SECOND_BYTE) begin
                        // restart the search
                        n_pos         = ibfr_pkg::POS_START;
                        o_sum_cmd.clr = 1'b1;
                    end else if (r_pos == ibfr_pkg::POS_CHK_HI) begin
                        n_pos         = ibfr_pkg::POS_START;
                        o_sum_cmd.clr = 1'b1;
                        if ({rx, r_chk_lo} == i_sum) begin
                            n_ch    = '0;
                            n_state = ST_RD_LO;
                        end
                    end else begin
                        o_we          = 1'b1;
                        o_sum_cmd.sub = (r_pos < ibfr_pkg::POS_CHK_LO);
                        n_pos         = r_pos + ibfr_pkg::ADDR_W'(1);
                    end
                end
            end
            ST_RD_LO: begin
                o_raddr = lo_addr;
                n_state = ST_RD_HI;
            end
            ST_RD_HI: begin
                o_raddr = hi_addr;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                // hold the high-byte address so the read data stays put
                o_raddr = hi_addr;
                if (!r_ovalid || o_out.ready) begin
                    load = 1'b1;
                    if (r_ch == ibfr_pkg::LAST_CH) begin
                        n_state = ST_RECV;
                    end else begin
                        n_ch    = r_ch + ibfr_pkg::CH_W'(1);
                        n_state = ST_RD_LO;
                    end
                end
            end
            default: begin
                n_state = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RECV;
            r_pos    <= ibfr_pkg::POS_START;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_ch    <= n_ch;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_pos == ibfr_pkg::POS_CHK_LO) begin
            r_chk_lo <= rx;
        end
        if (r_state == ST_RD_HI) begin
            r_lo <= i_rdata;
        end
        if (load) begin
            r_oidx  <= r_ch;
            r_oval  <= {i_rdata[ibfr_pkg::HI_BITS-1:0], r_lo};
            r_olast <= (r_ch == ibfr_pkg::LAST_CH);
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.channel_index = r_oidx;
    assign o_out.channel_value = r_oval;
    assign o_out.last          = r_olast;

endmodule

// ----- design/ibus_frame_receiver_top.sv -----
// Top level of the iBUS frame receiver.
`timescale 1ns / 1ps

// Receives serial bytes of 32-byte iBUS RC frames (0x20, 0x40, fourteen
// little-endian channel words, 16-bit checksum) and emits one result per
// channel, each value cut to 12 bits, with last set on channel 13. A frame
// with a wrong second byte restarts the search; a frame with a bad checksum
// is dropped silently. While a frame is being received the block takes one
// byte per cycle. After the final byte of a good frame it stops taking bytes
// until all 14 channels are read out, plus any output stall: each channel
// goes through a low byte read, a high byte read and an output load, set by
// the single read port of the frame RAM. A bad frame adds no pause.
module ibus_frame_receiver_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ibfr_in_if.sink    i_in,
    ibfr_out_if.source o_out
);

    ibfr_pkg::t_sum_cmd          sum_cmd;
    logic [ibfr_pkg::SUM_W-1:0]  sum;
    logic                        we;
    logic [ibfr_pkg::ADDR_W-1:0] waddr;
    logic [ibfr_pkg::BYTE_W-1:0] wdata;
    logic [ibfr_pkg::ADDR_W-1:0] raddr;
    logic [ibfr_pkg::BYTE_W-1:0] rdata;

    ibfr_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_sum_cmd (sum_cmd),
        .i_sum     (sum),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .i_rdata   (rdata)
    );

    ibfr_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (sum_cmd),
        .o_sum   (sum)
    );

    ibfr_ram #(
        .WIDTH (ibfr_pkg::BYTE_W),
        .DEPTH (ibfr_pkg::FRAME_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

// ----- design/ibfr_checker.sv -----
// Port-level assertions for the iBUS frame receiver, bound to the top level.
`timescale 1ns / 1ps

module ibfr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [ibfr_pkg::CH_W-1:0]    i_out_index,
    input logic [ibfr_pkg::VALUE_W-1:0] i_out_value,
    input logic                         i_out_last
);

    // a stalled request holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_index) && $stable(i_out_value)
            && $stable(i_out_last))
        else $error("output request dropped or changed while stalled");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_index <= ibfr_pkg::LAST_CH)
        else $error("channel index out of range");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == ibfr_pkg::LAST_CH)))
        else $error("last flag does not match final channel");

    // mid-frame readout holds off new bytes
    a_busy_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready during channel readout");

endmodule

bind ibus_frame_receiver_top ibfr_checker u_ibfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.channel_index),
    .i_out_value (o_out.channel_value),
    .i_out_last  (o_out.last)
);
